/* rtl/core/smc_pkg.sv */
// Shared types and constants for the secure memory card core.
// Used by smc_ctrl, smc_datapath and secure_memory_card_model_core.
package smc_pkg;

  localparam int MEM_BYTES  = 256;
  localparam int FUSE_COUNT = 4;
  localparam int MEM_AW     = $clog2(MEM_BYTES);

  // Application zone hidden while locked, and the manufacturer zone
  localparam int LOCK_LO = 176 / 8;
  localparam int LOCK_HI = 1408 / 8;
  localparam int MAN_LO  = 1424 / 8;
  localparam int MAN_HI  = 1440 / 8;

  // Fixed locations of the code bytes and the attempt counter
  localparam logic [MEM_AW-1:0] ADDR_CODE_HI = MEM_AW'(10);
  localparam logic [MEM_AW-1:0] ADDR_CODE_LO = MEM_AW'(11);
  localparam logic [MEM_AW-1:0] ADDR_ATTEMPT = MEM_AW'(12);

  localparam logic [7:0] BYTE_HEAD  = 8'h0f;
  localparam logic [7:0] BYTE_CODE  = 8'hf0;
  localparam logic [7:0] BYTE_BLANK = 8'hff;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_READ     = 3'd1,
    ACT_WRITE    = 3'd2,
    ACT_VALIDATE = 3'd3,
    ACT_FUSE     = 3'd4,
    ACT_POLL     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_NOCARD  = 2'd2,
    STAT_REFUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PRES_REL  = 2'd0,
    PRES_JDET = 2'd1,
    PRES_DET  = 2'd2,
    PRES_JREL = 2'd3
  } presence_t;

  localparam logic [1:0] CARD_BLANK  = 2'd0;
  localparam logic [1:0] CARD_BROKEN = 2'd2;

  localparam logic CFG_CARD_TYPE = 1'b0;
  localparam logic CFG_INSECURE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_INIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;        // action on the request in flight with no read or sweep, load result
    logic read_issue;  // latch address, start memory read
    logic read_done;   // memory data ready, load result
    logic init_start;  // latch fill pattern for initialize
    logic sweep;       // write one memory entry of the fill sweep
    logic init_done;   // initialize finished, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_valid;
  } sts_t;

endpackage

/* rtl/core/smc_ctrl.sv */
// Sequencing state machine for the secure memory card core.
// Depends on smc_pkg; drives smc_datapath through cmd_t.
module smc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2:0]            action,
  input  logic                  card_present,
  input  logic                  m_tready,
  input  smc_pkg::sts_t         sts,
  output smc_pkg::cmd_t         cmd
);

  smc_pkg::state_t state, state_next;
  logic            fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == smc_pkg::ST_IDLE) && (!sts.out_valid || m_tready);
  assign fire     = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      smc_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = smc_pkg::ST_IDLE;
        end
      end
      smc_pkg::ST_IDLE: begin
        if (fire) begin
          if (action == smc_pkg::ACT_INIT) begin
            cmd.init_start = 1'b1;
            state_next     = smc_pkg::ST_INIT;
          end else if (action == smc_pkg::ACT_READ && card_present) begin
            cmd.read_issue = 1'b1;
            state_next     = smc_pkg::ST_READ;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      smc_pkg::ST_READ: begin
        cmd.read_done = 1'b1;
        state_next    = smc_pkg::ST_IDLE;
      end
      smc_pkg::ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.init_done = 1'b1;
          state_next    = smc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smc_pkg::ST_IDLE;
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == smc_pkg::ST_IDLE)
    else $error("request taken outside idle");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.read_issue, cmd.read_done, cmd.init_start, cmd.sweep}))
    else $error("conflicting datapath commands");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.read_issue |=> cmd.read_done)
    else $error("read issue without completion");

endmodule

/* rtl/core/smc_datapath.sv */
// Card memory, fuses, lock and presence state, config registers and result register.
// Depends on smc_pkg; sequenced by smc_ctrl.
module smc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  smc_pkg::cmd_t         cmd,
  output smc_pkg::sts_t         sts,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [1:0]            cfg_data,
  input  logic [2:0]            action,
  input  logic                  card_present,
  input  logic [7:0]            byte_addr,
  input  logic [7:0]            write_data,
  input  logic [15:0]           pin_code,
  input  logic [1:0]            fuse_index,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [7:0]            read_data,
  output logic [1:0]            status,
  output logic [1:0]            presence
);

  localparam int AW = smc_pkg::MEM_AW;

  logic [7:0]                     mem [smc_pkg::MEM_BYTES];
  logic [7:0]                     mem_q;
  logic [AW-1:0]                  cnt;
  logic                           fill_zero;
  logic [smc_pkg::FUSE_COUNT-1:0] fuse_bits;
  logic                           unlocked;
  logic [1:0]                     pres;
  logic [1:0]                     card_type;
  logic                           insecure;
  logic [7:0]                     code_hi, code_lo, attempt;
  logic [7:0]                     addr_q;

  logic                           we;
  logic [AW-1:0]                  wa;
  logic [7:0]                     wd;
  logic [7:0]                     fill_byte;
  logic                           in_range, in_range_q, man_zone, lock_zone;
  logic                           code_match, write_ok;
  logic [1:0]                     pres_next;
  logic [1:0]                     exec_status;
  logic                           load;
  logic [7:0]                     load_data;
  logic [1:0]                     load_status;

  assign in_range   = {1'b0, byte_addr} < 9'(smc_pkg::MEM_BYTES);
  assign in_range_q = {1'b0, addr_q} < 9'(smc_pkg::MEM_BYTES);
  assign man_zone   = byte_addr >= 8'(smc_pkg::MAN_LO) && byte_addr < 8'(smc_pkg::MAN_HI);
  assign lock_zone  = addr_q >= 8'(smc_pkg::LOCK_LO) && addr_q < 8'(smc_pkg::LOCK_HI);
  assign code_match = pin_code[15:8] == code_hi && pin_code[7:0] == code_lo;
  assign write_ok   = in_range && !(man_zone && fuse_bits[0]) &&
                      card_type != smc_pkg::CARD_BROKEN;

  // Fill pattern for the sweep: all zeros, or the head/code/blank byte image
  always_comb begin
    if (fill_zero) begin
      fill_byte = 8'h00;
    end else if (cnt == AW'(0) || cnt == AW'(1)) begin
      fill_byte = smc_pkg::BYTE_HEAD;
    end else if (cnt == smc_pkg::ADDR_CODE_HI || cnt == smc_pkg::ADDR_CODE_LO) begin
      fill_byte = smc_pkg::BYTE_CODE;
    end else begin
      fill_byte = smc_pkg::BYTE_BLANK;
    end
  end

  // Debounce: just-detected/just-released step before settling
  always_comb begin
    if (card_present) begin
      pres_next = (pres == smc_pkg::PRES_JDET || pres == smc_pkg::PRES_DET) ?
                  smc_pkg::PRES_DET : smc_pkg::PRES_JDET;
    end else begin
      pres_next = (pres == smc_pkg::PRES_JREL || pres == smc_pkg::PRES_REL) ?
                  smc_pkg::PRES_REL : smc_pkg::PRES_JREL;
    end
  end

  // Memory write port and status of the actions run by exec
  always_comb begin
    we          = 1'b0;
    wa          = cnt;
    wd          = fill_byte;
    exec_status = smc_pkg::STAT_OK;
    if (cmd.sweep) begin
      we = 1'b1;
    end else if (cmd.exec) begin
      case (action) inside
        smc_pkg::ACT_READ, smc_pkg::ACT_FUSE: begin
          if (!card_present) exec_status = smc_pkg::STAT_NOCARD;
        end
        smc_pkg::ACT_WRITE: begin
          if (!card_present) begin
            exec_status = smc_pkg::STAT_NOCARD;
          end else if (!write_ok) begin
            exec_status = smc_pkg::STAT_REFUSED;
          end else begin
            we = 1'b1;
            wa = byte_addr[AW-1:0];
            wd = write_data;
          end
        end
        smc_pkg::ACT_VALIDATE: begin
          if (!card_present) begin
            exec_status = smc_pkg::STAT_NOCARD;
          end else begin
            we = 1'b1;
            wa = smc_pkg::ADDR_ATTEMPT;
            wd = code_match ? smc_pkg::BYTE_CODE : {1'b0, attempt[7:1]};
            if (!code_match) exec_status = smc_pkg::STAT_REJECT;
          end
        end
        default: begin
          exec_status = smc_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.read_issue) begin
      mem_q  <= mem[byte_addr[AW-1:0]];
      addr_q <= byte_addr;
    end
  end

  // Shadow copies of the code and attempt bytes, kept in step with the memory
  always_ff @(posedge clk) begin
    if (we) begin
      if (wa == smc_pkg::ADDR_CODE_HI) code_hi <= wd;
      if (wa == smc_pkg::ADDR_CODE_LO) code_lo <= wd;
      if (wa == smc_pkg::ADDR_ATTEMPT) attempt <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      fill_zero <= 1'b1;
      fuse_bits <= '0;
      unlocked  <= 1'b0;
      pres      <= smc_pkg::PRES_REL;
      card_type <= 2'd1;
      insecure  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == smc_pkg::CFG_CARD_TYPE) card_type <= cfg_data;
        if (cfg_index == smc_pkg::CFG_INSECURE)  insecure  <= cfg_data[0];
      end
      if (cmd.sweep) begin
        cnt <= sts.sweep_last ? '0 : cnt + AW'(1);
      end
      if (cmd.init_start) begin
        fill_zero <= card_type == smc_pkg::CARD_BLANK;
        if (card_type != smc_pkg::CARD_BLANK) fuse_bits <= '0;
      end
      if (cmd.exec && card_present) begin
        if (action == smc_pkg::ACT_VALIDATE && code_match) unlocked <= 1'b1;
        if (action == smc_pkg::ACT_FUSE &&
            32'(fuse_index) < smc_pkg::FUSE_COUNT) begin
          fuse_bits <= fuse_bits | (smc_pkg::FUSE_COUNT'(1) << fuse_index);
        end
      end
      if (cmd.exec && action == smc_pkg::ACT_POLL) begin
        pres <= pres_next;
      end
    end
  end

  // Result register
  assign load = cmd.exec || cmd.read_done || cmd.init_done;

  always_comb begin
    load_data   = 8'h00;
    load_status = smc_pkg::STAT_OK;
    if (cmd.read_done) begin
      if (!in_range_q) begin
        load_data = 8'h00;
      end else if (lock_zone && !unlocked && !insecure) begin
        load_data = smc_pkg::BYTE_BLANK;
      end else begin
        load_data = mem_q;
      end
    end else if (cmd.exec) begin
      load_status = exec_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data <= load_data;
      status    <= load_status;
      presence  <= (cmd.exec && action == smc_pkg::ACT_POLL) ? pres_next : pres;
    end
  end

  assign sts.sweep_last = cnt == AW'(smc_pkg::MEM_BYTES - 1);
  assign sts.out_valid  = m_tvalid;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load && m_tvalid |-> m_tready)
    else $error("result loaded over an undelivered one");

  a_cnt_parked: assert property (@(posedge clk) disable iff (rst)
    !cmd.sweep |-> cnt == '0)
    else $error("sweep counter not parked");

  a_unlock_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(unlocked) && !$past(rst) |-> unlocked)
    else $error("card relocked");

endmodule

/* rtl/core/secure_memory_card_model_core.sv */
// Top level of the PIN-protected memory card core.
// Depends on smc_pkg, smc_ctrl and smc_datapath.
//
// Each request carries one card action (initialize, read, write, validate code,
// blow fuse, poll presence) and returns exactly one result with the byte read,
// a status code and the debounced presence state. The core works on one request
// at a time. Write, validate, blow fuse, poll, and any action refused for lack of
// a card are handled directly from idle; read passes through a read state (the
// card memory has a registered read port); initialize sweeps the whole 256-byte
// memory at one byte per cycle. The result sits in an output register, and the
// next request is taken in the cycle that result is taken. After reset the core
// clears the card memory before taking requests; configuration writes are
// accepted at any time, but should be issued only while the core is idle.
module secure_memory_card_model_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration: index 0 card_type, index 1 insecure_override
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // card_present[0], byte_addr[8:1], write_data[16:9],
                                // pin_code[32:17], fuse_index[34:33], zero fill
  input  logic [2:0]  s_tuser,  // action[2:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // read_data[7:0], status[9:8], presence[11:10], zero fill
);

  smc_pkg::cmd_t cmd;
  smc_pkg::sts_t sts;

  logic [7:0] read_data;
  logic [1:0] status;
  logic [1:0] presence;

  smc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .action       (s_tuser),
    .card_present (s_tdata[0]),
    .m_tready     (m_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  smc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (s_tuser),
    .card_present (s_tdata[0]),
    .byte_addr    (s_tdata[8:1]),
    .write_data   (s_tdata[16:9]),
    .pin_code     (s_tdata[32:17]),
    .fuse_index   (s_tdata[34:33]),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .read_data    (read_data),
    .status       (status),
    .presence     (presence)
  );

  assign m_tdata = {4'h0, presence, status, read_data};

endmodule
